// ===== sv/ceb_pkg.sv =====
// cursor edit char buffer: shared sizes, function codes, cell command type
// and the result-width helper. depends on nothing.
package ceb_pkg;

  localparam int CAPACITY = 256;
  localparam int CHAR_W   = 8;
  localparam int FUNC_W   = 3;
  localparam int OFS_W    = 10;
  localparam int COUNT_W  = 9;
  localparam int RES_W    = 9;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = $clog2(CAPACITY + 1);
  // wide enough for position sums and a full offset magnitude
  localparam int WIDE_W   = ((POS_W > OFS_W) ? POS_W : OFS_W) + 1;
  localparam int RD_GRP   = 16;
  localparam int RD_NGRP  = (CAPACITY + RD_GRP - 1) / RD_GRP;

  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  localparam logic [FUNC_W-1:0] FUNC_OVERWRITE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MOVE_REL   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MOVE_ABS   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_READ_INDEX = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_CURRENT    = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RESET      = 3'd7;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   pos;
    logic [CHAR_W-1:0]  ch;
    logic [IDX_W-1:0]   rd_addr;
  } cell_cmd_t;

  function automatic logic [RES_W-1:0] to_res(input logic [POS_W-1:0] p);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(p);
    return w[RES_W-1:0];
  endfunction

endpackage

// ===== sv/cursor_edit_char_buffer_core.sv =====
// top level of the cursor edit char buffer: sequencer, cursor and length
// registers, result register. uses ceb_pkg, ceb_cell and ceb_rd_tree.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------
//   input   | in_valid  | in_stall  | func, char_in, offset, count, advance
//   output  | out_valid | out_stall | ok, char_out, cursor, length
//
// overwrite, insert, moves and reset finish as the beat is taken: the whole
// cell row writes or shifts right at once. reads pass accept, two or-tree
// stages and the result register in turn. a delete that keeps a tail runs
// the shift state, moving its tail left one position a cycle. reset clears
// cursor and length; cell bytes are not cleared. a stalled result holds, and
// a new beat is taken only once the result register is free or being emptied.
module cursor_edit_char_buffer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ceb_pkg::FUNC_W-1:0]        func,
  input  logic [ceb_pkg::CHAR_W-1:0]        char_in,
  input  logic signed [ceb_pkg::OFS_W-1:0]  offset,
  input  logic [ceb_pkg::COUNT_W-1:0]       count,
  input  logic                              advance,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic [ceb_pkg::CHAR_W-1:0]        char_out,
  output logic [ceb_pkg::RES_W-1:0]         cursor,
  output logic [ceb_pkg::RES_W-1:0]         length
);
  import ceb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_RD1,
    ST_RD2,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [POS_W-1:0]     cur;
  logic [POS_W-1:0]     len;
  logic [COUNT_W-1:0]   shift_cnt;
  logic                 rd_hit;
  logic [IDX_W-1:0]     rd_addr;

  logic                 out_free;
  logic                 acc;
  logic                 res_load;

  // next values decoded from the incoming beat
  logic [POS_W-1:0]     cur_next;
  logic [POS_W-1:0]     len_next;
  logic                 ok_next;
  logic                 rd_hit_next;
  logic [IDX_W-1:0]     rd_addr_next;
  logic                 go_shift;
  logic                 go_read;
  cell_op_t             op_next;

  logic                 off_neg;
  logic [OFS_W-1:0]     back10;
  logic [WIDE_W-1:0]    back_w;
  logic [WIDE_W-1:0]    pos_w;
  logic [WIDE_W-1:0]    cur_w;
  logic [WIDE_W-1:0]    len_w;
  logic [WIDE_W-1:0]    cnt_w;
  logic [WIDE_W-1:0]    sum_w;

  cell_cmd_t                          cmd;
  logic [CAPACITY-1:0][CHAR_W-1:0]    cell_data;
  logic [CAPACITY-1:0][CHAR_W-1:0]    cell_rd;
  logic [CHAR_W-1:0]                  tree_data;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign acc      = in_valid && !in_stall;
  // result register loads a new beat this cycle
  assign res_load = ((state == ST_IDLE) && acc && !go_shift && !go_read) ||
                    ((state == ST_FINISH) && out_free);

  assign off_neg = offset[OFS_W-1];
  assign back10  = $unsigned(~offset) + 10'd1;
  assign back_w  = WIDE_W'(back10);
  assign pos_w   = WIDE_W'(offset[OFS_W-2:0]);
  assign cur_w   = WIDE_W'(cur);
  assign len_w   = WIDE_W'(len);
  assign cnt_w   = WIDE_W'(count);
  assign sum_w   = cur_w + pos_w;

  always_comb begin
    cur_next     = cur;
    len_next     = len;
    ok_next      = 1'b1;
    rd_hit_next  = 1'b0;
    rd_addr_next = rd_addr;
    go_shift     = 1'b0;
    go_read      = 1'b0;
    op_next      = CELL_HOLD;
    case (func)
      FUNC_OVERWRITE: begin
        if (cur == len && len == CAP_POS) begin
          ok_next = 1'b0;
        end else begin
          op_next  = CELL_WRITE;
          cur_next = cur + 1'b1;
          if (cur == len) len_next = len + 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (len == CAP_POS) begin
          ok_next = 1'b0;
        end else begin
          op_next  = CELL_INSERT;
          cur_next = cur + 1'b1;
          len_next = len + 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (cnt_w >= len_w - cur_w) begin
          len_next = cur;
        end else if (count != '0) begin
          len_next = POS_W'(len_w - cnt_w);
          go_shift = 1'b1;
        end
      end
      FUNC_MOVE_REL: begin
        if (off_neg) cur_next = (back_w >= cur_w) ? '0 : POS_W'(cur_w - back_w);
        else         cur_next = (sum_w > len_w) ? len : POS_W'(sum_w);
      end
      FUNC_MOVE_ABS: begin
        if (off_neg || pos_w > len_w) cur_next = len;
        else                          cur_next = POS_W'(pos_w);
      end
      FUNC_READ_INDEX: begin
        rd_hit_next  = !off_neg && (pos_w < len_w);
        rd_addr_next = IDX_W'(pos_w);
        go_read      = 1'b1;
      end
      FUNC_CURRENT: begin
        rd_hit_next  = cur < len;
        rd_addr_next = IDX_W'(cur);
        go_read      = 1'b1;
        if (advance && cur < len) cur_next = cur + 1'b1;
      end
      FUNC_RESET: begin
        cur_next = '0;
        len_next = '0;
      end
      default: begin
      end
    endcase
  end

  // command broadcast along the cell row
  always_comb begin
    cmd.op      = CELL_HOLD;
    cmd.pos     = IDX_W'(cur);
    cmd.ch      = char_in;
    cmd.rd_addr = rd_addr;
    if (acc) cmd.op = op_next;
    else if (state == ST_SHIFT) cmd.op = CELL_SHIFT;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CHAR_W-1:0] left_in;
    logic [CHAR_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ceb_cell u_cell (
      .clk    (clk),
      .idx    (IDX_W'(i)),
      .cmd    (cmd),
      .left   (left_in),
      .right  (right_in),
      .data   (cell_data[i]),
      .rd_out (cell_rd[i])
    );
  end

  ceb_rd_tree u_rd_tree (
    .clk     (clk),
    .cell_rd (cell_rd),
    .rd_data (tree_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            cur       <= cur_next;
            len       <= len_next;
            rd_hit    <= rd_hit_next;
            rd_addr   <= rd_addr_next;
            shift_cnt <= count;
            if (go_shift) begin
              state <= ST_SHIFT;
            end else if (go_read) begin
              state <= ST_RD1;
            end else begin
              ok        <= ok_next;
              char_out  <= '0;
              cursor    <= to_res(cur_next);
              length    <= to_res(len_next);
            end
          end
        end
        ST_SHIFT: begin
          shift_cnt <= shift_cnt - 1'b1;
          if (shift_cnt == COUNT_W'(1)) state <= ST_FINISH;
        end
        ST_RD1: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            ok        <= 1'b1;
            char_out  <= rd_hit ? tree_data : '0;
            cursor    <= to_res(cur);
            length    <= to_res(len);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_cur_in_text: assert property (@(posedge clk) disable iff (rst) cur <= len)
    else $error("cursor beyond text length");

  a_len_in_cap: assert property (@(posedge clk) disable iff (rst) len <= CAP_POS)
    else $error("text length beyond capacity");

  a_beat_tracked: assert property (@(posedge clk) disable iff (rst)
    acc |=> (out_valid || state != ST_IDLE))
    else $error("accepted beat left no result and no work in flight");

  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (shift_cnt != '0))
    else $error("delete shift running with zero count");

endmodule

// ===== sv/ceb_cell.sv =====
// one character cell of the buffer chain: holds a byte, takes from its left
// neighbor on insert and from its right neighbor on a delete shift. uses ceb_pkg.
module ceb_cell (
  input  logic                          clk,
  input  logic [ceb_pkg::IDX_W-1:0]     idx,
  input  ceb_pkg::cell_cmd_t            cmd,
  input  logic [ceb_pkg::CHAR_W-1:0]    left,
  input  logic [ceb_pkg::CHAR_W-1:0]    right,
  output logic [ceb_pkg::CHAR_W-1:0]    data,
  output logic [ceb_pkg::CHAR_W-1:0]    rd_out
);
  import ceb_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_WRITE: begin
        if (idx == cmd.pos) data <= cmd.ch;
      end
      CELL_INSERT: begin
        if (idx == cmd.pos) data <= cmd.ch;
        else if (idx > cmd.pos) data <= left;
      end
      CELL_SHIFT: begin
        if (idx >= cmd.pos) data <= right;
      end
      default: begin
      end
    endcase
  end

  // only the addressed cell puts its byte on the read tree
  assign rd_out = (idx == cmd.rd_addr) ? data : '0;

endmodule

// ===== sv/ceb_rd_tree.sv =====
// two-stage registered or-tree that collects the addressed cell's byte.
// uses ceb_pkg; fed by the ceb_cell chain.
module ceb_rd_tree (
  input  logic                                              clk,
  input  logic [ceb_pkg::CAPACITY-1:0][ceb_pkg::CHAR_W-1:0] cell_rd,
  output logic [ceb_pkg::CHAR_W-1:0]                        rd_data
);
  import ceb_pkg::*;

  logic [RD_NGRP-1:0][CHAR_W-1:0] grp;
  logic [RD_NGRP-1:0][CHAR_W-1:0] grp_next;
  logic [CHAR_W-1:0]              all_or;

  always_comb begin
    for (int g = 0; g < RD_NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < RD_GRP; k++) begin
        if (g * RD_GRP + k < CAPACITY) grp_next[g] = grp_next[g] | cell_rd[g * RD_GRP + k];
      end
    end
  end

  always_comb begin
    all_or = '0;
    for (int g = 0; g < RD_NGRP; g++) all_or = all_or | grp[g];
  end

  always_ff @(posedge clk) begin
    grp     <= grp_next;
    rd_data <= all_or;
  end

endmodule
